### rtl/flic_lrd_pkg.sv
// Shared types and constants for the FLI line run decoder.
// Request payload structs, config struct, phase enum, register indexes.
// No dependencies.
`default_nettype none

package flic_lrd_pkg;

    localparam int ADDR_W = 20;
    localparam int LEN_W  = 9;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DELTA_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd200;

    localparam logic [LEN_W-1:0] FULL_RUN = 9'd256;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_DONE   = 4'd1,
        PH_HDR0   = 4'd2,
        PH_HDR1   = 4'd3,
        PH_HDR2   = 4'd4,
        PH_HDR3   = 4'd5,
        PH_PKTCNT = 4'd6,
        PH_SKIP   = 4'd7,
        PH_COUNT  = 4'd8,
        PH_FILL   = 4'd9,
        PH_LIT    = 4'd10
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] span_addr;
        logic [LEN_W-1:0]  span_len;
        logic [7:0]        span_value;
        logic              span_valid;
        logic              done_res;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic             delta_mode;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/flic_lrd_core.sv
// Decoder state registers and single-step next-state / span logic.
// Depends on flic_lrd_pkg.
`default_nettype none

module flic_lrd_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  flic_lrd_pkg::t_in_item  i_item,
    input  flic_lrd_pkg::t_cfg      i_cfg,
    output logic                    o_res_valid,
    output flic_lrd_pkg::t_out_item o_res
);
    import flic_lrd_pkg::*;

    localparam logic [CFG_W:0] W_LIM = (MAX_WIDTH > 2047) ? 12'd2047 : 12'(MAX_WIDTH);
    localparam logic [CFG_W:0] H_LIM = (MAX_HEIGHT > 2047) ? 12'd2047 : 12'(MAX_HEIGHT);

    t_phase            r_phase, n_phase;
    logic [15:0]       r_lines, n_lines;
    logic [7:0]        r_packets, n_packets;
    logic [15:0]       r_column, n_column;
    logic [ADDR_W-1:0] r_row_base, n_row_base;
    logic [LEN_W-1:0]  r_lit_left, n_lit_left;
    logic [7:0]        r_hdr_low, n_hdr_low;
    logic              r_end_after, n_end_after;

    logic [CFG_W-1:0]  use_w;
    logic [CFG_W-1:0]  use_h;

    assign use_w = ({1'b0, i_cfg.frame_width} > W_LIM) ? W_LIM[CFG_W-1:0] : i_cfg.frame_width;
    assign use_h = ({1'b0, i_cfg.frame_height} > H_LIM) ? H_LIM[CFG_W-1:0] : i_cfg.frame_height;

    always_comb begin
        logic [7:0]        b;
        logic              w_en;
        logic              d_en;
        logic [ADDR_W-1:0] s_addr;
        logic [LEN_W-1:0]  s_len;
        logic [7:0]        s_val;
        logic              do_after_run;
        logic              do_end_line;
        logic [15:0]       lines_dec;
        logic [7:0]        pk_dec;
        logic [ADDR_W-1:0] base_inc;
        logic [ADDR_W-1:0] cur_addr;
        logic [26:0]       prod;
        t_phase            pkt_phase;
        logic              is_fill;
        logic [LEN_W-1:0]  raw_len;
        logic [LEN_W-1:0]  run_len;
        logic [16:0]       run_end;
        logic              clip;

        b            = i_item.data_byte;
        w_en         = 1'b0;
        d_en         = 1'b0;
        s_addr       = '0;
        s_len        = '0;
        s_val        = '0;
        do_after_run = 1'b0;
        do_end_line  = 1'b0;

        n_phase     = r_phase;
        n_lines     = r_lines;
        n_packets   = r_packets;
        n_column    = r_column;
        n_row_base  = r_row_base;
        n_lit_left  = r_lit_left;
        n_hdr_low   = r_hdr_low;
        n_end_after = r_end_after;

        if (i_item.chunk_start) begin
            n_lines     = '0;
            n_packets   = '0;
            n_column    = '0;
            n_row_base  = '0;
            n_lit_left  = '0;
            n_hdr_low   = '0;
            n_end_after = 1'b0;
            if (i_cfg.delta_mode) begin
                n_phase = PH_HDR0;
            end else begin
                n_lines = 16'(use_h);
                n_phase = PH_PKTCNT;
                if (use_h == '0) begin
                    n_phase = PH_DONE;
                    d_en    = 1'b1;
                end
            end
        end

        lines_dec = n_lines - 16'd1;
        pk_dec    = n_packets - 8'd1;
        base_inc  = n_row_base + ADDR_W'(use_w);
        cur_addr  = n_row_base + ADDR_W'(n_column);
        prod      = 27'({b, n_hdr_low}) * 27'(use_w);
        pkt_phase = i_cfg.delta_mode ? PH_SKIP : PH_COUNT;

        is_fill = i_cfg.delta_mode ? ((b == 8'd0) || b[7]) : !b[7];
        if (b == 8'd0) begin
            raw_len = FULL_RUN;
        end else if (b[7]) begin
            raw_len = FULL_RUN - {1'b0, b};
        end else begin
            raw_len = {1'b0, b};
        end
        run_end = {1'b0, n_column} + 17'(raw_len);
        clip    = run_end > 17'(use_w);
        if (!clip) begin
            run_len = raw_len;
        end else if (n_column < 16'(use_w)) begin
            run_len = LEN_W'(16'(use_w) - n_column);
        end else begin
            run_len = '0;
        end

        if (!d_en) begin
            unique case (n_phase)
                PH_HDR0: begin
                    n_hdr_low = b;
                    n_phase   = PH_HDR1;
                end
                PH_HDR1: begin
                    n_row_base = prod[ADDR_W-1:0];
                    n_phase    = PH_HDR2;
                end
                PH_HDR2: begin
                    n_hdr_low = b;
                    n_phase   = PH_HDR3;
                end
                PH_HDR3: begin
                    n_lines = {b, n_hdr_low};
                    if ({b, n_hdr_low} == 16'd0) begin
                        n_phase = PH_DONE;
                        d_en    = 1'b1;
                    end else begin
                        n_phase = PH_PKTCNT;
                    end
                end
                PH_PKTCNT: begin
                    n_column  = '0;
                    n_packets = b;
                    if (b == 8'd0) begin
                        do_end_line = 1'b1;
                    end else begin
                        n_phase = pkt_phase;
                    end
                end
                PH_SKIP: begin
                    n_column = n_column + 16'(b);
                    n_phase  = PH_COUNT;
                end
                PH_COUNT: begin
                    if (clip) begin
                        n_end_after = 1'b1;
                    end
                    n_lit_left = run_len;
                    if (is_fill) begin
                        n_phase = PH_FILL;
                    end else if (run_len == '0) begin
                        w_en    = 1'b1;
                        s_addr  = cur_addr;
                        n_phase = PH_DONE;
                        d_en    = 1'b1;
                    end else begin
                        n_phase = PH_LIT;
                    end
                end
                PH_FILL: begin
                    w_en         = 1'b1;
                    s_addr       = cur_addr;
                    s_len        = n_lit_left;
                    s_val        = b;
                    n_column     = n_column + 16'(n_lit_left);
                    n_lit_left   = '0;
                    do_after_run = 1'b1;
                end
                PH_LIT: begin
                    w_en       = 1'b1;
                    s_addr     = cur_addr;
                    s_len      = 9'd1;
                    s_val      = b;
                    n_column   = n_column + 16'd1;
                    n_lit_left = n_lit_left - 9'd1;
                    if (n_lit_left == '0) begin
                        do_after_run = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_after_run) begin
            if (n_end_after) begin
                n_phase = PH_DONE;
                d_en    = 1'b1;
            end else begin
                n_packets = pk_dec;
                if (pk_dec == 8'd0) begin
                    do_end_line = 1'b1;
                end else begin
                    n_phase = pkt_phase;
                end
            end
        end

        if (do_end_line) begin
            n_lines    = lines_dec;
            n_row_base = base_inc;
            if (lines_dec == 16'd0) begin
                n_phase = PH_DONE;
                d_en    = 1'b1;
            end else begin
                n_phase = PH_PKTCNT;
            end
        end

        o_res_valid      = w_en || d_en;
        o_res.span_addr  = s_addr;
        o_res.span_len   = s_len;
        o_res.span_value = s_val;
        o_res.span_valid = w_en;
        o_res.done_res   = d_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_lines     <= '0;
            r_packets   <= '0;
            r_column    <= '0;
            r_row_base  <= '0;
            r_lit_left  <= '0;
            r_hdr_low   <= '0;
            r_end_after <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_lines     <= n_lines;
            r_packets   <= n_packets;
            r_column    <= n_column;
            r_row_base  <= n_row_base;
            r_lit_left  <= n_lit_left;
            r_hdr_low   <= n_hdr_low;
            r_end_after <= n_end_after;
        end
    end

endmodule

`default_nettype wire

### rtl/flic_line_run_decoder_top.sv
// Top level of the FLI line run decoder: handshakes, config registers, I/O registers.
// Depends on flic_lrd_pkg and flic_lrd_core.
`default_nettype none

// Takes one chunk byte per request and returns at most one result (a span
// write, a chunk-done marker, or both) per byte. A new byte can be taken every
// cycle while the output side is not stalling; each byte passes an input
// register, one decode step against the state registers, and an output
// register. The decode step holds the 16x11 bit multiply of the delta start
// line by the frame width. Config writes are always ready and take effect at
// once; write them only while the block idles.
module flic_line_run_decoder_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  flic_lrd_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output flic_lrd_pkg::t_out_item               o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [flic_lrd_pkg::IDX_W-1:0]        i_cfg_index,
    input  wire  [flic_lrd_pkg::CFG_W-1:0]        i_cfg_data
);
    import flic_lrd_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      adv;
    logic      step_en;
    logic      in_take;
    logic      res_valid;
    t_out_item res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.delta_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                CFG_DELTA_MODE:   r_cfg.delta_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign adv        = !r_out_valid || !i_out_stall;
    assign step_en    = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    flic_lrd_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step_en),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= step_en && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.span_valid || o_out_data.done_res))
        else $error("result with neither write nor done");

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.span_valid) |->
            (o_out_data.span_addr == '0 && o_out_data.span_len == '0 &&
             o_out_data.span_value == '0))
        else $error("done-only result carries span fields");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.span_len <= FULL_RUN))
        else $error("span length above full run");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("held request lost while output stalled");

endmodule

`default_nettype wire
